>>> src/mtvs_pkg.sv
`timescale 1ns / 1ps

package mtvs_pkg;

   localparam int MAX_STOPS_DEFAULT = 64;

   // Field widths of the two channels.
   localparam int STOP_W = 6;
   localparam int DIST_W = 32;
   localparam int VIOL_W = 33;
   localparam int SIZE_W = 7;

   // A stored entry is a missing flag over a 31-bit non-negative value.
   localparam int VAL_W    = DIST_W - 1;
   localparam int ENTRY_W  = VAL_W + 1;
   localparam int MISS_BIT = VAL_W;

   // Register file of the configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic {
      CSR_SIZE_IN_USE = 1'b0,
      CSR_UNUSED      = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_RUN   = 1'b1
   } op_type;

   // Which matrix entries a read fetches: the pair entry d[i][j], or the
   // two entries d[i][k] and d[j][k] of one triple.
   typedef enum logic {
      RD_IJ = 1'b0,
      RD_K  = 1'b1
   } rd_kind_type;

   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      rd_kind_type rd_kind;
      logic        clear_best;
      logic        publish;
   } cmd_type;

   typedef struct packed {
      logic ij_ready;
      logic ij_missing;
      logic busy;
   } status_type;

endpackage

>>> src/mtvs_ctrl.sv
`timescale 1ns / 1ps

module mtvs_ctrl #(
   parameter int MAX_STOPS = mtvs_pkg::MAX_STOPS_DEFAULT,
   localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  mtvs_pkg::op_type            req_op,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [mtvs_pkg::SIZE_W-1:0] size_in_use,
   output mtvs_pkg::cmd_type           cmd,
   input  mtvs_pkg::status_type        status,
   output logic [IDX_W-1:0]            idx_i,
   output logic [IDX_W-1:0]            idx_j,
   output logic [IDX_W-1:0]            idx_k
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IJ_ISSUE,
      ST_IJ_WAIT,
      ST_K_SCAN,
      ST_DRAIN,
      ST_PUBLISH
   } state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] i_ff;
   logic [IDX_W-1:0] j_ff;
   logic [IDX_W-1:0] k_ff;

   logic [31:0]      n_full;
   logic             n_empty;
   logic [IDX_W-1:0] n_last;
   logic             accept;
   logic             last_i;
   logic             last_j;
   logic             last_k;

   // The scanned dimension saturates at the matrix size.
   assign n_full  = (32'(size_in_use) > 32'(MAX_STOPS)) ? 32'(MAX_STOPS)
                                                        : 32'(size_in_use);
   assign n_empty = (n_full == 32'd0);
   assign n_last  = IDX_W'(n_full - 32'd1);

   assign last_i = (i_ff == n_last);
   assign last_j = (j_ff == n_last);
   assign last_k = (k_ff == n_last);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign idx_i     = i_ff;
   assign idx_j     = j_ff;
   assign idx_k     = k_ff;

   always_comb begin
      cmd = '0;
      cmd.rd_kind = mtvs_pkg::RD_IJ;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_en      = accept && (req_op == mtvs_pkg::OP_WRITE);
            cmd.clear_best = accept && (req_op == mtvs_pkg::OP_RUN);
         end
         ST_IJ_ISSUE: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_kind = mtvs_pkg::RD_IJ;
         end
         ST_K_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_kind = mtvs_pkg::RD_K;
         end
         ST_PUBLISH: begin
            cmd.publish = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_op == mtvs_pkg::OP_RUN)) begin
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= n_empty ? ST_DRAIN : ST_IJ_ISSUE;
               end
            end
            ST_IJ_ISSUE: begin
               state_ff <= ST_IJ_WAIT;
            end
            ST_IJ_WAIT: begin
               if (status.ij_ready) begin
                  if (!status.ij_missing) begin
                     k_ff     <= '0;
                     state_ff <= ST_K_SCAN;
                  end else if (last_j) begin
                     j_ff <= '0;
                     if (last_i) begin
                        state_ff <= ST_DRAIN;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_IJ_ISSUE;
                     end
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_IJ_ISSUE;
                  end
               end
            end
            ST_K_SCAN: begin
               if (!last_k) begin
                  k_ff <= k_ff + 1'b1;
               end else if (last_j) begin
                  j_ff <= '0;
                  if (last_i) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_IJ_ISSUE;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= ST_IJ_ISSUE;
               end
            end
            ST_DRAIN: begin
               if (!status.busy) begin
                  state_ff <= ST_PUBLISH;
               end
            end
            ST_PUBLISH: begin
               if (cmd.publish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> src/mtvs_datapath.sv
`timescale 1ns / 1ps

module mtvs_datapath #(
   parameter int MAX_STOPS = mtvs_pkg::MAX_STOPS_DEFAULT,
   localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mtvs_pkg::cmd_type                  cmd,
   output mtvs_pkg::status_type               status,
   input  logic [IDX_W-1:0]                   idx_i,
   input  logic [IDX_W-1:0]                   idx_j,
   input  logic [IDX_W-1:0]                   idx_k,
   input  logic [mtvs_pkg::STOP_W-1:0]        wr_row,
   input  logic [mtvs_pkg::STOP_W-1:0]        wr_col,
   input  logic signed [mtvs_pkg::DIST_W-1:0] wr_distance,
   input  logic                               wr_missing,
   output logic signed [mtvs_pkg::VIOL_W-1:0] out_max_violation,
   output logic [mtvs_pkg::STOP_W-1:0]        out_first_stop,
   output logic [mtvs_pkg::STOP_W-1:0]        out_middle_stop,
   output logic [mtvs_pkg::STOP_W-1:0]        out_last_stop,
   output logic                               out_found
);

   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int EXT_W  = IDX_W + mtvs_pkg::STOP_W;

   logic [mtvs_pkg::ENTRY_W-1:0] dist_mem [DEPTH];

   logic [EXT_W-1:0]             row_ext;
   logic [EXT_W-1:0]             col_ext;
   logic                         wr_in_range;
   logic [ADDR_W-1:0]            wr_addr;
   logic [mtvs_pkg::ENTRY_W-1:0] wr_entry;
   logic [ADDR_W-1:0]            rd_addr_a;
   logic [ADDR_W-1:0]            rd_addr_b;

   logic [mtvs_pkg::ENTRY_W-1:0] rd_a_ff;
   logic [mtvs_pkg::ENTRY_W-1:0] rd_b_ff;
   logic                         s1_valid_ff;
   mtvs_pkg::rd_kind_type        s1_kind_ff;
   logic [IDX_W-1:0]             s1_i_ff;
   logic [IDX_W-1:0]             s1_j_ff;
   logic [IDX_W-1:0]             s1_k_ff;
   logic [mtvs_pkg::VAL_W-1:0]   eij_ff;

   logic                              s2_valid_in;
   logic signed [mtvs_pkg::VIOL_W-1:0] s2_v_in;
   logic                              s2_valid_ff;
   logic signed [mtvs_pkg::VIOL_W-1:0] s2_v_ff;
   logic [IDX_W-1:0]                  s2_i_ff;
   logic [IDX_W-1:0]                  s2_j_ff;
   logic [IDX_W-1:0]                  s2_k_ff;

   logic                              found_ff;
   logic signed [mtvs_pkg::VIOL_W-1:0] best_ff;
   logic [IDX_W-1:0]                  best_i_ff;
   logic [IDX_W-1:0]                  best_j_ff;
   logic [IDX_W-1:0]                  best_k_ff;
   logic [EXT_W-1:0]                  best_i_ext;
   logic [EXT_W-1:0]                  best_j_ext;
   logic [EXT_W-1:0]                  best_k_ext;

   logic signed [mtvs_pkg::VIOL_W-1:0] out_viol_ff;
   logic [mtvs_pkg::STOP_W-1:0]       out_first_ff;
   logic [mtvs_pkg::STOP_W-1:0]       out_middle_ff;
   logic [mtvs_pkg::STOP_W-1:0]       out_last_ff;
   logic                              out_found_ff;

   // Writes outside the matrix are dropped; negative values are stored as missing.
   assign row_ext     = EXT_W'(wr_row);
   assign col_ext     = EXT_W'(wr_col);
   assign wr_in_range = (32'(wr_row) < 32'(MAX_STOPS)) && (32'(wr_col) < 32'(MAX_STOPS));
   assign wr_addr     = {row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]};
   assign wr_entry    = (wr_missing || wr_distance[mtvs_pkg::DIST_W-1])
                        ? {1'b1, {mtvs_pkg::VAL_W{1'b0}}}
                        : {1'b0, wr_distance[mtvs_pkg::VAL_W-1:0]};

   assign rd_addr_a = (cmd.rd_kind == mtvs_pkg::RD_IJ) ? {idx_i, idx_j} : {idx_i, idx_k};
   assign rd_addr_b = {idx_j, idx_k};

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_range) begin
         dist_mem[wr_addr] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= dist_mem[rd_addr_a];
         rd_b_ff <= dist_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s2_valid_in;
      end
      s1_kind_ff <= cmd.rd_kind;
      s1_i_ff    <= idx_i;
      s1_j_ff    <= idx_j;
      s1_k_ff    <= idx_k;
      if (s1_valid_ff && (s1_kind_ff == mtvs_pkg::RD_IJ)) begin
         eij_ff <= rd_a_ff[mtvs_pkg::VAL_W-1:0];
      end
      s2_v_ff <= s2_v_in;
      s2_i_ff <= s1_i_ff;
      s2_j_ff <= s1_j_ff;
      s2_k_ff <= s1_k_ff;
   end

   assign status.ij_ready   = s1_valid_ff && (s1_kind_ff == mtvs_pkg::RD_IJ);
   assign status.ij_missing = rd_a_ff[mtvs_pkg::MISS_BIT];
   assign status.busy       = s1_valid_ff || s2_valid_ff;

   // The pair entry is known present here: the controller skips a missing one.
   assign s2_valid_in = s1_valid_ff && (s1_kind_ff == mtvs_pkg::RD_K)
                        && !rd_a_ff[mtvs_pkg::MISS_BIT] && !rd_b_ff[mtvs_pkg::MISS_BIT];
   assign s2_v_in = $signed({2'b00, rd_a_ff[mtvs_pkg::VAL_W-1:0]})
                    - $signed({2'b00, eij_ff})
                    - $signed({2'b00, rd_b_ff[mtvs_pkg::VAL_W-1:0]});

   // Strict greater-than keeps the earliest triple on a tie.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.clear_best) begin
         found_ff <= 1'b0;
      end else if (s2_valid_ff) begin
         found_ff <= 1'b1;
      end
      if (cmd.clear_best) begin
         best_ff   <= '0;
         best_i_ff <= '0;
         best_j_ff <= '0;
         best_k_ff <= '0;
      end else if (s2_valid_ff && (!found_ff || (s2_v_ff > best_ff))) begin
         best_ff   <= s2_v_ff;
         best_i_ff <= s2_i_ff;
         best_j_ff <= s2_j_ff;
         best_k_ff <= s2_k_ff;
      end
   end

   assign best_i_ext = EXT_W'(best_i_ff);
   assign best_j_ext = EXT_W'(best_j_ff);
   assign best_k_ext = EXT_W'(best_k_ff);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_viol_ff   <= best_ff;
         out_first_ff  <= best_i_ext[mtvs_pkg::STOP_W-1:0];
         out_middle_ff <= best_j_ext[mtvs_pkg::STOP_W-1:0];
         out_last_ff   <= best_k_ext[mtvs_pkg::STOP_W-1:0];
         out_found_ff  <= found_ff;
      end
   end

   assign out_max_violation = out_viol_ff;
   assign out_first_stop    = out_first_ff;
   assign out_middle_stop   = out_middle_ff;
   assign out_last_stop     = out_last_ff;
   assign out_found         = out_found_ff;

endmodule

>>> src/max_triangle_violation_search.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Contents
// req_*     in         req_valid/req_ready   op, row/col index, distance, missing flag
// rsp_*     out        rsp_valid/rsp_ready   max violation, i/j/k stops, found
// APB       in         psel/penable, pready  size_in_use at byte address 0
//
// A write transaction stores its entry and leaves the block idle. A run transaction
// walks every (i,j) pair: it fetches d[i][j] and, when that entry is present, scans
// every k, reading each new triple while earlier ones are still evaluated. A triple
// takes d[i][k] and d[j][k] from the two read ports of the distance memory.
// Reset is synchronous and sets size_in_use to 64; the matrix holds no reset value.
// The finished result sits in an output register, so write transactions are taken
// while it waits; a run completes its scan and then holds until rsp_ready frees it.

module max_triangle_violation_search #(
   parameter int MAX_STOPS = mtvs_pkg::MAX_STOPS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [mtvs_pkg::STOP_W-1:0]           req_row_index,
   input  logic [mtvs_pkg::STOP_W-1:0]           req_col_index,
   input  logic signed [mtvs_pkg::DIST_W-1:0]    req_distance_value,
   input  logic                                  req_is_missing,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mtvs_pkg::VIOL_W-1:0]    rsp_max_violation,
   output logic [mtvs_pkg::STOP_W-1:0]           rsp_first_stop,
   output logic [mtvs_pkg::STOP_W-1:0]           rsp_middle_stop,
   output logic [mtvs_pkg::STOP_W-1:0]           rsp_last_stop,
   output logic                                  rsp_found,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mtvs_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [mtvs_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [mtvs_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

   logic [mtvs_pkg::SIZE_W-1:0] size_ff;
   mtvs_pkg::csr_index_type     csr_index;
   mtvs_pkg::cmd_type           cmd;
   mtvs_pkg::status_type        status;
   mtvs_pkg::op_type            op;
   logic [IDX_W-1:0]            idx_i;
   logic [IDX_W-1:0]            idx_j;
   logic [IDX_W-1:0]            idx_k;

   assign pready    = 1'b1;
   assign csr_index = mtvs_pkg::csr_index_type'(paddr[2]);
   assign op        = mtvs_pkg::op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mtvs_pkg::SIZE_RESET;
      end else if (psel && penable && pwrite && pready
                   && (csr_index == mtvs_pkg::CSR_SIZE_IN_USE)) begin
         size_ff <= pwdata[mtvs_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      case (csr_index)
         mtvs_pkg::CSR_SIZE_IN_USE: prdata = mtvs_pkg::CSR_DATA_W'(size_ff);
         default:                   prdata = '0;
      endcase
   end

   mtvs_ctrl #(
      .MAX_STOPS(MAX_STOPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_op     (op),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .size_in_use(size_ff),
      .cmd        (cmd),
      .status     (status),
      .idx_i      (idx_i),
      .idx_j      (idx_j),
      .idx_k      (idx_k)
   );

   mtvs_datapath #(
      .MAX_STOPS(MAX_STOPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .idx_i            (idx_i),
      .idx_j            (idx_j),
      .idx_k            (idx_k),
      .wr_row           (req_row_index),
      .wr_col           (req_col_index),
      .wr_distance      (req_distance_value),
      .wr_missing       (req_is_missing),
      .out_max_violation(rsp_max_violation),
      .out_first_stop   (rsp_first_stop),
      .out_middle_stop  (rsp_middle_stop),
      .out_last_stop    (rsp_last_stop),
      .out_found        (rsp_found)
   );

endmodule
